FILE: src/assert_macros.svh
// assertion macros shared by the noise generator rtl
// no dependencies; bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");
`else
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`define ASSERT_SAME(name, clk, rst, ante, cons)
`endif
`endif

FILE: src/glng_pkg.sv
// shared constants, register codes and types of the gated noise generator
// no dependencies
package glng_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 24;

   localparam int unsigned LCG_BITS    = 32;
   localparam int unsigned AMP_BITS    = 17;
   localparam int unsigned LEN_BITS    = 24;
   localparam int unsigned GAIN_BITS   = 24;
   localparam int unsigned MAG_BITS    = 23;
   localparam int unsigned NOISE_LSB   = 9;
   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned FULL_SHIFT  = 15;   // 32767 = 2^15 - 1
   localparam int unsigned PROD_BITS   = 54;   // 32767 * amplitude * magnitude
   localparam int unsigned SPLIT_BITS  = 27;
   localparam int unsigned PART_BITS   = SPLIT_BITS + GAIN_BITS;
   localparam int unsigned FRAC_BITS   = 38;
   localparam int unsigned SUM_BITS    = 79;
   localparam int unsigned QUO_BITS    = 17;
   localparam int unsigned DIV_CNT_BITS = 5;
   localparam int unsigned MUL_BITS    = 32;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [LCG_BITS-1:0] SEED_RESET = 32'hCAFE_BABE;
   localparam logic [LCG_BITS-1:0] LCG_MUL    = 32'd1664525;
   localparam logic [LCG_BITS-1:0] LCG_ADD    = 32'd1013904223;
   localparam logic [MAG_BITS-1:0] NOISE_MID  = 23'h40_0000;
   localparam logic [AMP_BITS-1:0] AMP_RESET  = 17'd26214;
   localparam logic [LEN_BITS-1:0] RAMP_RESET = 24'd12000;
   localparam logic [LEN_BITS-1:0] TOTAL_RESET = 24'd48000;
   localparam logic [QUO_BITS-1:0] POS_LIMIT  = 17'd32767;
   localparam logic [QUO_BITS-1:0] NEG_LIMIT  = 17'd32768;
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST_STEP = DIV_CNT_BITS'(QUO_BITS - 1);

   localparam int unsigned CSR_ADDR_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SEED      = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_AMPLITUDE = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RAMP_LEN  = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TOTAL_LEN = 2'd3;

   typedef struct packed {
      logic [LCG_BITS-1:0] seed;
      logic [AMP_BITS-1:0] amplitude;
      logic [LEN_BITS-1:0] ramp_len;
      logic [LEN_BITS-1:0] total_len;
   } glng_cfg_type;

   // one tick after the generator step and gate lookup
   typedef struct packed {
      logic [MAG_BITS-1:0]  mag;
      logic                 neg;
      logic [GAIN_BITS-1:0] gain;
      logic                 last;
   } glng_item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_P,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_SUM,
      BK_DIV,
      BK_OUT
   } glng_back_state_type;

endpackage

FILE: src/glng_front.sv
// front end: takes ticks, steps the lcg, tracks the burst index and gate gain
// depends on glng_pkg
module glng_front import glng_pkg::*; #(
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  glng_cfg_type  cfg,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          restart,
   output logic          push_valid,
   input  logic          push_ready,
   output glng_item_type push_item
);

   localparam int unsigned CMP_BITS = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;

   logic [LCG_BITS-1:0]   state_ff, state_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [LCG_BITS-1:0]   hold_lcg_ff, hold_lcg_in;
   logic [GAIN_BITS-1:0]  hold_gain_ff, hold_gain_in;
   logic                  hold_last_ff, hold_last_in;

   logic                  accept;
   logic [LCG_BITS-1:0]   base;
   logic [LCG_BITS-1:0]   lcg_next;
   logic [COUNT_BITS-1:0] cur_idx;
   logic [CMP_BITS-1:0]   idx_w, ramp_w, total_w;
   logic                  last_w;
   logic [GAIN_BITS-1:0]  gain_w;
   logic [MAG_BITS-1:0]   noise_u;

   assign req_tready = !hold_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      base     = restart ? cfg.seed : state_ff;
      cur_idx  = restart ? '0 : idx_ff;
      lcg_next = LCG_BITS'(base * LCG_MUL + LCG_ADD);
      idx_w    = CMP_BITS'(cur_idx);
      ramp_w   = CMP_BITS'(cfg.ramp_len);
      total_w  = CMP_BITS'(cfg.total_len);
      last_w   = (idx_w + CMP_BITS'(1)) >= total_w;
      // fade-in, flat top, then fade-out; zero ramp means unity gate
      if (cfg.ramp_len == '0) begin
         gain_w = GAIN_BITS'(1);
      end else if (idx_w < ramp_w) begin
         gain_w = idx_w[GAIN_BITS-1:0];
      end else if ((idx_w + ramp_w) > total_w) begin
         if (idx_w >= total_w) begin
            gain_w = '0;
         end else begin
            gain_w = GAIN_BITS'(total_w - idx_w);
         end
      end else begin
         gain_w = cfg.ramp_len;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      hold_lcg_in   = hold_lcg_ff;
      hold_gain_in  = hold_gain_ff;
      hold_last_in  = hold_last_ff;
      hold_valid_in = push_ready ? 1'b0 : hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_lcg_in   = lcg_next;
         hold_gain_in  = gain_w;
         hold_last_in  = last_w;
         state_in      = last_w ? cfg.seed : lcg_next;
         idx_in        = last_w ? '0 : COUNT_BITS'(cur_idx + COUNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEED_RESET;
         idx_ff        <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_lcg_ff  <= hold_lcg_in;
      hold_gain_ff <= hold_gain_in;
      hold_last_ff <= hold_last_in;
   end

   // top 23 bits offset by half scale, kept as sign and magnitude
   assign noise_u = hold_lcg_ff[LCG_BITS-1:NOISE_LSB];

   always_comb begin
      push_item.neg  = !noise_u[MAG_BITS-1];
      push_item.mag  = noise_u[MAG_BITS-1] ? {1'b0, noise_u[MAG_BITS-2:0]}
                                           : MAG_BITS'(NOISE_MID - noise_u);
      push_item.gain = hold_gain_ff;
      push_item.last = hold_last_ff;
   end

   assign push_valid = hold_valid_ff;

endmodule

FILE: src/glng_queue.sv
// short fifo between front and back ends
// depends on glng_pkg
module glng_queue import glng_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  glng_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output glng_item_type pop_item
);

   localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);

   glng_item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]      count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = count_ff != (PTR_BITS+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PTR_BITS'(wr_ptr_ff + PTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_BITS'(rd_ptr_ff + PTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/glng_back.sv
// back end: gain scaling on a shared multiplier, rounding divide by ramp length,
// saturation and the output register; depends on glng_pkg
module glng_back import glng_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  glng_cfg_type                  cfg,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  glng_item_type                 pop_item,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_last
);

   glng_back_state_type state_ff, state_in;

   logic [MAG_BITS-1:0]     mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [GAIN_BITS-1:0]    gain_ff, gain_in;
   logic                    item_last_ff, item_last_in;
   logic [PROD_BITS-1:0]    p_ff, p_in;
   logic [PART_BITS-1:0]    lo_ff, lo_in;
   logic [PART_BITS-1:0]    hi_ff, hi_in;
   logic [LEN_BITS-1:0]     rem_ff, rem_in;
   logic [QUO_BITS-1:0]     quo_ff, quo_in;
   logic                    sat_ff, sat_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [MUL_BITS-1:0]     mul_a, mul_b;
   logic [2*MUL_BITS-1:0]   mul_p;
   logic [MUL_BITS-1:0]     amp_scaled;
   logic [LEN_BITS-1:0]     ramp_eff;
   logic [SUM_BITS-1:0]     sum_w;
   logic [LEN_BITS+1:0]     trial;
   logic [QUO_BITS-1:0]     res;
   logic [QUO_BITS-1:0]     res_clip;
   logic                    out_free;

   assign mul_p      = mul_a * mul_b;
   assign amp_scaled = (MUL_BITS'(cfg.amplitude) << FULL_SHIFT) - MUL_BITS'(cfg.amplitude);
   assign ramp_eff   = (cfg.ramp_len == '0) ? LEN_BITS'(1) : cfg.ramp_len;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (pop_valid) state_in = BK_MUL_P;
         BK_MUL_P:  state_in = BK_MUL_LO;
         BK_MUL_LO: state_in = BK_MUL_HI;
         BK_MUL_HI: state_in = BK_SUM;
         BK_SUM:    state_in = BK_DIV;
         BK_DIV:    if (cnt_ff == DIV_LAST_STEP) state_in = BK_OUT;
         BK_OUT:    if (out_free) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop_ready    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      gain_in      = gain_ff;
      item_last_in = item_last_ff;
      p_in         = p_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sat_in       = sat_ff;
      cnt_in       = cnt_ff;
      sample_in    = sample_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      sum_w = SUM_BITS'({hi_ff, SPLIT_BITS'(0)}) + SUM_BITS'(lo_ff)
            + (SUM_BITS'(ramp_eff) << (FRAC_BITS - 1));
      trial = {1'b0, rem_ff, quo_ff[QUO_BITS-1]} - {2'b00, ramp_eff};
      res   = sat_ff ? '1 : quo_ff;
      if (neg_ff) begin
         res_clip = (res > NEG_LIMIT) ? NEG_LIMIT : res;
      end else begin
         res_clip = (res > POS_LIMIT) ? POS_LIMIT : res;
      end
      case (state_ff)
         BK_IDLE: begin
            pop_ready    = 1'b1;
            mag_in       = pop_item.mag;
            neg_in       = pop_item.neg;
            gain_in      = pop_item.gain;
            item_last_in = pop_item.last;
         end
         BK_MUL_P: begin
            mul_a = amp_scaled;
            mul_b = MUL_BITS'(mag_ff);
            p_in  = mul_p[PROD_BITS-1:0];
         end
         BK_MUL_LO: begin
            mul_a = MUL_BITS'(p_ff[SPLIT_BITS-1:0]);
            mul_b = MUL_BITS'(gain_ff);
            lo_in = mul_p[PART_BITS-1:0];
         end
         BK_MUL_HI: begin
            mul_a = MUL_BITS'(p_ff[PROD_BITS-1:SPLIT_BITS]);
            mul_b = MUL_BITS'(gain_ff);
            hi_in = mul_p[PART_BITS-1:0];
         end
         BK_SUM: begin
            // half of the divisor is added first, so truncation rounds half up
            rem_in = sum_w[SUM_BITS-1:FRAC_BITS+QUO_BITS];
            quo_in = sum_w[FRAC_BITS+QUO_BITS-1:FRAC_BITS];
            sat_in = sum_w[SUM_BITS-1:FRAC_BITS+QUO_BITS] >= ramp_eff;
            cnt_in = '0;
         end
         BK_DIV: begin
            if (!trial[LEN_BITS+1]) begin
               rem_in = trial[LEN_BITS-1:0];
               quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[LEN_BITS-2:0], quo_ff[QUO_BITS-1]};
               quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + DIV_CNT_BITS'(1);
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = item_last_ff;
               sample_in    = neg_ff ? SAMPLE_BITS'(QUO_BITS'(0) - res_clip)
                                     : res_clip[SAMPLE_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      gain_ff      <= gain_in;
      item_last_ff <= item_last_in;
      p_ff         <= p_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      sat_ff       <= sat_in;
      cnt_ff       <= cnt_in;
      sample_ff    <= sample_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: src/gated_lcg_noise_generator.sv
// top level of the gated lcg noise generator: register file and the three stages
// depends on glng_pkg, glng_front, glng_queue, glng_back and assert_macros.svh
//
// Each accepted transaction is one tick and yields one 16-bit noise sample, with
// tlast on the final sample of each gated burst. The front end registers an accepted
// tick in its hold register and hands it on to a two-entry queue; the back end then
// takes each sample through a fetch, three passes through its shared 32x32
// multiplier, one wide rounding add and a 17-step restoring divide by the ramp
// length, and then into the output register once that is free. It takes no new
// item from the queue until it has finished the last, so sustained throughput is
// set by the back end's divider and multiplier sequence. Register writes must be
// made while no sample is in flight; a new seed takes effect at the next burst
// start or restart.
`include "assert_macros.svh"

module gated_lcg_noise_generator import glng_pkg::*; #(
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] restart, [7:1] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [SAMPLE_BITS-1:0] rsp_tdata,   // [15:0] sample
   output logic                          rsp_tlast,
   input  logic                          csr_wr_en,
   input  logic [CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   glng_cfg_type  cfg_ff, cfg_in;
   logic          q_push_valid, q_push_ready;
   glng_item_type q_push_item;
   logic          q_pop_valid, q_pop_ready;
   glng_item_type q_pop_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            CSR_SEED:      cfg_in.seed      = csr_wdata[LCG_BITS-1:0];
            CSR_AMPLITUDE: cfg_in.amplitude = csr_wdata[AMP_BITS-1:0];
            CSR_RAMP_LEN:  cfg_in.ramp_len  = csr_wdata[LEN_BITS-1:0];
            CSR_TOTAL_LEN: cfg_in.total_len = csr_wdata[LEN_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed      <= SEED_RESET;
         cfg_ff.amplitude <= AMP_RESET;
         cfg_ff.ramp_len  <= RAMP_RESET;
         cfg_ff.total_len <= TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   glng_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .restart    (req_tdata[0]),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item)
   );

   glng_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   glng_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_sample (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

   // an accepted tick is held by the front end in the following cycle
   `ASSERT_NEXT(a_front_fills, clock, reset, req_tvalid && req_tready, q_push_valid)
   // the back end works on one item at a time once it has taken one
   `ASSERT_NEXT(a_back_busy, clock, reset, q_pop_valid && q_pop_ready, !q_pop_ready)
   // nothing is in flight right after reset
   `ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid && !q_push_valid)

endmodule
